// ----- hdl/gconn_pkg.sv -----
// Shared types, constants and helpers for the graph connectivity checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package gconn_pkg;

  localparam int NODE_W = 6;
  localparam int ROW_W  = 64;
  localparam int CNT_W  = 7;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_CHECK = 1'b1
  } gconn_op_t;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // write one adjacency row
    logic start;  // clear visited, seed node 0, latch node mask
    logic pick;   // pop lowest pending node, issue its row read
    logic merge;  // fold fetched row into pending
    logic emit;   // load the result register
  } gconn_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic pend_empty;
    logic out_busy;
  } gconn_sts_t;

  function automatic logic [NODE_W-1:0] lowest_bit(input logic [ROW_W-1:0] x);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (x[i]) idx = NODE_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/graph_connectivity_check_top.sv -----
// Graph connectivity checker: adjacency store with a bitmask walk from node 0.
// Usage:
//   Input channel (in_valid / in_stall): in_opcode selects a row load or a
//   check. A load writes in_neighbour_mask as the row of in_node_index and
//   gives no result; loads are taken one per cycle while idle. Rows at or
//   beyond MAX_NODES are dropped.
//   A check walks from node 0 and gives one item on the output channel
//   (out_valid / out_stall): out_is_connected and out_reached_count.
//   For each reached node (up to node_count), the walk picks it and issues
//   its row read from the adjacency memory, then merges the row into the
//   pending set. The input is stalled for the whole walk; loads resume the
//   cycle the result is registered. cfg_we / cfg_wdata write node_count
//   (reset value 64); the user writes it only while idle, which the block
//   itself does not enforce. If the receiver stalls, the result is held and
//   a finished walk waits for the output register to free up before the
//   block goes idle.
//   Reset (rst_n low, synchronous) clears control state, the visited and
//   pending sets and the output valid. Adjacency rows are not cleared and
//   must be written before a check reads them.
`default_nettype none

module graph_connectivity_check_top #(
  parameter int MAX_NODES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_opcode,
  input  wire logic [gconn_pkg::NODE_W-1:0]  in_node_index,
  input  wire logic [gconn_pkg::ROW_W-1:0]   in_neighbour_mask,
  input  wire logic                          cfg_we,
  input  wire logic [gconn_pkg::CNT_W-1:0]   cfg_wdata,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_is_connected,
  output logic [gconn_pkg::CNT_W-1:0]        out_reached_count
);
  import gconn_pkg::*;

  gconn_cmd_t cmd;
  gconn_sts_t sts;

  gconn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gconn_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_node_index     (in_node_index),
    .in_neighbour_mask (in_neighbour_mask),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .sts               (sts),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_is_connected  (out_is_connected),
    .out_reached_count (out_reached_count)
  );

endmodule

`default_nettype wire

// ----- hdl/gconn_ctrl.sv -----
// Controller state machine of the graph connectivity checker.
// Depends on gconn_pkg; drives datapath commands from its status.
`default_nettype none

module gconn_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_opcode,
  output logic                      in_stall,
  input  wire gconn_pkg::gconn_sts_t sts,
  output gconn_pkg::gconn_cmd_t     cmd
);
  import gconn_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PICK  = 4'b0010,
    ST_FETCH = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_CHECK) begin
            cmd.start = 1'b1;
            state_nxt = ST_PICK;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_PICK: begin
        if (sts.pend_empty) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.pick  = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.merge = 1'b1;
        state_nxt = ST_PICK;
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/gconn_dp.sv -----
// Datapath of the graph connectivity checker: adjacency memory, visited and
// pending sets, reach counter, node count register and result register.
// Depends on gconn_pkg.
`default_nettype none

module gconn_dp #(
  parameter int MAX_NODES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [gconn_pkg::NODE_W-1:0]  in_node_index,
  input  wire logic [gconn_pkg::ROW_W-1:0]   in_neighbour_mask,
  input  wire logic                          cfg_we,
  input  wire logic [gconn_pkg::CNT_W-1:0]   cfg_wdata,
  input  wire gconn_pkg::gconn_cmd_t         cmd,
  output gconn_pkg::gconn_sts_t              sts,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic                               out_is_connected,
  output logic [gconn_pkg::CNT_W-1:0]        out_reached_count
);
  import gconn_pkg::*;

  localparam int               AW   = $clog2(MAX_NODES);
  localparam logic [CNT_W-1:0] MAXN = CNT_W'(MAX_NODES);

  logic [ROW_W-1:0] mem [MAX_NODES];
  logic [ROW_W-1:0] rd_data_r;

  logic [CNT_W-1:0] node_count_r;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] n_r;
  logic [ROW_W-1:0] mask_nxt, mask_r;
  logic [ROW_W-1:0] visited_r, pending_r;
  logic [CNT_W-1:0] count_r;
  logic [NODE_W-1:0] v_sel;
  logic [ROW_W-1:0] v_bit;
  logic             wr_ok;

  logic             out_valid_r, out_conn_r;
  logic [CNT_W-1:0] out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n)      node_count_r <= NODE_COUNT_RST;
    else if (cfg_we) node_count_r <= cfg_wdata;
  end

  // zero counts as one node, anything past the store as a full store
  assign n_eff = (node_count_r == '0)  ? CNT_W'(1) :
                 (node_count_r > MAXN) ? MAXN : node_count_r;

  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      mask_nxt[j] = (CNT_W'(j) < n_eff);
    end
  end

  assign v_sel = lowest_bit(pending_r);
  assign v_bit = ROW_W'(1) << v_sel;
  assign wr_ok = ({1'b0, in_node_index} < MAXN);

  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) mem[in_node_index[AW-1:0]] <= in_neighbour_mask;
    if (cmd.pick)          rd_data_r <= mem[v_sel[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      pending_r <= '0;
      count_r   <= '0;
    end else if (cmd.start) begin
      visited_r <= '0;
      pending_r <= ROW_W'(1);
      count_r   <= '0;
    end else if (cmd.pick) begin
      // pending and visited stay disjoint, so every pop is a new node
      visited_r <= visited_r | v_bit;
      pending_r <= pending_r & ~v_bit;
      count_r   <= count_r + CNT_W'(1);
    end else if (cmd.merge) begin
      pending_r <= pending_r | (rd_data_r & mask_r & ~visited_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mask_r <= mask_nxt;
      n_r    <= n_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)                        out_valid_r <= 1'b0;
    else if (cmd.emit)                 out_valid_r <= 1'b1;
    else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_conn_r  <= (count_r == n_r);
      out_count_r <= count_r;
    end
  end

  assign sts = '{pend_empty: (pending_r == '0), out_busy: (out_valid_r && out_stall)};

  assign out_valid         = out_valid_r;
  assign out_is_connected  = out_conn_r;
  assign out_reached_count = out_count_r;

endmodule

`default_nettype wire

// ----- hdl/gconn_checker.sv -----
// Port-level checks for graph_connectivity_check_top, bound to the top level.
// Depends on gconn_pkg.
`default_nettype none

module gconn_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          in_opcode,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          out_is_connected,
  input wire logic [gconn_pkg::CNT_W-1:0]   out_reached_count
);
  import gconn_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_reached_count)
      && $stable(out_is_connected))
    else $error("result changed while stalled");

  // node 0 is always reached, and the count never exceeds 64
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reached_count != '0 && out_reached_count <= 7'd64)
    else $error("reached count out of range");

  // an accepted check raises the input stall
  a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_opcode == OP_CHECK |=> in_stall)
    else $error("input taken during a walk");

  // a new result only comes out of a walk
  a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a walk");

endmodule

bind graph_connectivity_check_top gconn_checker u_gconn_checker (.*);

`default_nettype wire
